@@ hdl/fir_filter_scatter_accumulate_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef FIR_FILTER_SCATTER_ACCUMULATE_MACROS_SVH
`define FIR_FILTER_SCATTER_ACCUMULATE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FIRSA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("firsa: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FIRSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("firsa: next-cycle check failed");

`endif

@@ hdl/firsa_pkg.sv @@
package firsa_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int TAP_W       = 18;
  localparam int INDEX_W     = 6;
  localparam int COUNT_W     = 7;
  localparam int GAIN_W      = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int ACC_W       = 48;
  localparam int PROD_W      = SAMPLE_W + TAP_W;
  localparam int GPROD_W     = ACC_W + GAIN_W;
  localparam int ROUND_SHIFT = 29;
  localparam int Y_W         = GPROD_W - ROUND_SHIFT;

  localparam logic signed [GPROD_W-1:0] ROUND_BIAS = GPROD_W'(64'sd1 <<< (ROUND_SHIFT - 1));
  localparam logic signed [Y_W-1:0] Y_MAX = Y_W'(35'sd8388607);
  localparam logic signed [Y_W-1:0] Y_MIN = Y_W'(-35'sd8388608);
  localparam logic signed [SAMPLE_W-1:0] OUT_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] OUT_MIN = 24'sh800000;

  localparam logic [COUNT_W-1:0]       TAP_COUNT_RESET   = 7'd64;
  localparam logic signed [GAIN_W-1:0] OUTPUT_GAIN_RESET = 16'sd4096;

  localparam logic OP_SAMPLE   = 1'b0;
  localparam logic OP_LOAD_TAP = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_TAP_COUNT   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_GAIN = 1'b1;

  typedef struct packed {
    logic clear_step;
    logic take_item;
    logic mod_step;
    logic mac_issue;
    logic gain_load;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic mod_done;
    logic mac_last;
    logic sum_ready;
    logic out_busy;
  } dp_status_t;

endpackage

@@ hdl/fir_filter_scatter_accumulate.sv @@
// Channel   Handshake                    Payload
// item      item_valid / item_stall      opcode, sample_in, tap_index, tap_value
// result    result_valid / result_stall  sample_out, saturated
// config    cfg_write                    cfg_index, cfg_data
//
// A load-tap beat is taken in S_IDLE; a sample beat runs S_MOD, S_MAC, S_DRAIN, S_GAIN, S_OUT
// and stalls new items until done, the single multiply-accumulate sweeping the accumulator
// memory port once per tap. After tap_count shrinks, S_MOD reduces the ring position by
// repeated subtraction. After reset a clearing pass zeroes both memories with item_stall high.
// A finished result waits in the output register, so the next item is taken while it is stalled.
module fir_filter_scatter_accumulate #(
  parameter int MAX_TAPS = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   item_valid,
  output logic                                   item_stall,
  input  logic                                   opcode,
  input  logic signed [firsa_pkg::SAMPLE_W-1:0]  sample_in,
  input  logic [firsa_pkg::INDEX_W-1:0]          tap_index,
  input  logic signed [firsa_pkg::TAP_W-1:0]     tap_value,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic signed [firsa_pkg::SAMPLE_W-1:0]  sample_out,
  output logic                                   saturated,
  input  logic                                   cfg_write,
  input  logic [firsa_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [firsa_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import firsa_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  firsa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .opcode     (opcode),
    .status     (status),
    .item_stall (item_stall),
    .cmd        (cmd)
  );

  firsa_datapath #(
    .MAX_TAPS (MAX_TAPS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .opcode       (opcode),
    .sample_in    (sample_in),
    .tap_index    (tap_index),
    .tap_value    (tap_value),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .sample_out   (sample_out),
    .saturated    (saturated)
  );

endmodule

@@ hdl/firsa_ctrl.sv @@
module firsa_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  input  logic                   opcode,
  input  firsa_pkg::dp_status_t  status,
  output logic                   item_stall,
  output firsa_pkg::dp_cmd_t     cmd
);
  import firsa_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_MAC   = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_GAIN  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign item_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.take_item = 1'b1;
          if (opcode == OP_SAMPLE) begin
            state_next = S_MOD;
          end
        end
      end
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (status.mod_done) begin
          state_next = S_MAC;
        end
      end
      S_MAC: begin
        cmd.mac_issue = 1'b1;
        if (status.mac_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (status.sum_ready) begin
          state_next = S_GAIN;
        end
      end
      S_GAIN: begin
        cmd.gain_load = 1'b1;
        state_next    = S_OUT;
      end
      S_OUT: begin
        if (!status.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/firsa_datapath.sv @@
module firsa_datapath #(
  parameter int MAX_TAPS = 64
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  firsa_pkg::dp_cmd_t                        cmd,
  output firsa_pkg::dp_status_t                     status,
  input  logic                                      opcode,
  input  logic signed [firsa_pkg::SAMPLE_W-1:0]     sample_in,
  input  logic [firsa_pkg::INDEX_W-1:0]             tap_index,
  input  logic signed [firsa_pkg::TAP_W-1:0]        tap_value,
  input  logic                                      cfg_write,
  input  logic [firsa_pkg::CFG_INDEX_W-1:0]         cfg_index,
  input  logic [firsa_pkg::CFG_DATA_W-1:0]          cfg_data,
  input  logic                                      result_stall,
  output logic                                      result_valid,
  output logic signed [firsa_pkg::SAMPLE_W-1:0]     sample_out,
  output logic                                      saturated
);
  import firsa_pkg::*;

  localparam int AW = $clog2(MAX_TAPS);
  localparam int NW = $clog2(MAX_TAPS + 1);
  localparam int CW = (NW > COUNT_W) ? NW : COUNT_W;
  localparam logic [CW-1:0] MAX_TAPS_C = CW'(MAX_TAPS);
  localparam logic [AW-1:0] LAST_ADDR  = AW'(MAX_TAPS - 1);

  logic [COUNT_W-1:0]       tap_count;
  logic signed [GAIN_W-1:0] output_gain;

  logic signed [TAP_W-1:0] tap_mem [MAX_TAPS];
  logic signed [ACC_W-1:0] acc_mem [MAX_TAPS];

  logic [AW-1:0] clr_addr;
  logic [AW-1:0] ring_pos;
  logic [AW-1:0] p;
  logic [NW-1:0] n_taps;
  logic [NW-1:0] n_in;
  logic [CW-1:0] count_ext;
  logic signed [SAMPLE_W-1:0] x;
  logic [AW-1:0] slot_cnt;
  logic [AW-1:0] tap_cnt;
  logic          mod_done;
  logic          slot_wrap;

  logic signed [TAP_W-1:0] tap_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [AW-1:0]           s1_slot;
  logic                    s1_v;
  logic                    s1_last;

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc2;
  logic [AW-1:0]            s2_slot;
  logic                     s2_v;
  logic                     s2_last;
  logic signed [ACC_W-1:0]  sum;

  logic signed [ACC_W-1:0]   emit_acc;
  logic                      sum_ready;
  logic signed [GPROD_W-1:0] gain_prod;
  logic signed [GPROD_W-1:0] rounded;
  logic signed [Y_W-1:0]     y_full;
  logic signed [SAMPLE_W-1:0] y_sat;
  logic                      y_clip;

  logic                    tap_ok;
  logic                    tap_we;
  logic [AW-1:0]           tap_wa;
  logic signed [TAP_W-1:0] tap_wd;
  logic                    acc_we;
  logic [AW-1:0]           acc_wa;
  logic signed [ACC_W-1:0] acc_wd;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count   <= TAP_COUNT_RESET;
      output_gain <= OUTPUT_GAIN_RESET;
    end else if (cfg_write) begin
      if (cfg_index == REG_TAP_COUNT) begin
        tap_count <= cfg_data[COUNT_W-1:0];
      end
      if (cfg_index == REG_OUTPUT_GAIN) begin
        output_gain <= cfg_data;
      end
    end
  end

  assign count_ext = CW'(tap_count);

  always_comb begin
    priority if (count_ext == '0) begin
      n_in = NW'(1);
    end else if (count_ext > MAX_TAPS_C) begin
      n_in = NW'(MAX_TAPS);
    end else begin
      n_in = NW'(count_ext);
    end
  end

  assign mod_done  = (NW'(p) < n_taps);
  assign slot_wrap = (NW'(slot_cnt) == (n_taps - NW'(1)));

  // The work copy of the ring position is reduced by repeated subtraction, then seeds the
  // slot and tap counters for the multiply-accumulate sweep.
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      x      <= sample_in;
      n_taps <= n_in;
      p      <= ring_pos;
    end else if (cmd.mod_step) begin
      if (!mod_done) begin
        p <= AW'(NW'(p) - n_taps);
      end else begin
        slot_cnt <= p;
        tap_cnt  <= AW'(n_taps - NW'(1));
      end
    end else if (cmd.mac_issue) begin
      slot_cnt <= slot_wrap ? '0 : slot_cnt + AW'(1);
      tap_cnt  <= tap_cnt - AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= (clr_addr == LAST_ADDR) ? '0 : clr_addr + AW'(1);
    end
  end

  assign tap_ok = (int'(tap_index) < MAX_TAPS);
  assign tap_we = cmd.clear_step || (cmd.take_item && (opcode == OP_LOAD_TAP) && tap_ok);
  assign tap_wa = cmd.clear_step ? clr_addr : AW'(tap_index);
  assign tap_wd = cmd.clear_step ? '0 : tap_value;

  always_ff @(posedge clk) begin
    if (tap_we) begin
      tap_mem[tap_wa] <= tap_wd;
    end
    tap_q <= tap_mem[tap_cnt];
  end

  assign sum    = acc2 + ACC_W'(prod);
  assign acc_we = cmd.clear_step || s2_v;
  assign acc_wa = cmd.clear_step ? clr_addr : s2_slot;
  assign acc_wd = (cmd.clear_step || s2_last) ? '0 : sum;

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_wa] <= acc_wd;
    end
    acc_q <= acc_mem[slot_cnt];
  end

  always_ff @(posedge clk) begin
    s1_slot <= slot_cnt;
    prod    <= PROD_W'(x) * PROD_W'(tap_q);
    acc2    <= acc_q;
    s2_slot <= s1_slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v    <= 1'b0;
      s1_last <= 1'b0;
      s2_v    <= 1'b0;
      s2_last <= 1'b0;
    end else begin
      s1_v    <= cmd.mac_issue;
      s1_last <= cmd.mac_issue && (tap_cnt == '0);
      s2_v    <= s1_v;
      s2_last <= s1_last;
    end
  end

  // The slot of the last tap is the one due now: its sum leaves and the slot is written as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_ready <= 1'b0;
      ring_pos  <= '0;
    end else if (s2_v && s2_last) begin
      sum_ready <= 1'b1;
      ring_pos  <= s2_slot;
    end else if (cmd.gain_load) begin
      sum_ready <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v && s2_last) begin
      emit_acc <= sum;
    end
    if (cmd.gain_load) begin
      gain_prod <= GPROD_W'(emit_acc) * GPROD_W'(output_gain);
    end
  end

  assign rounded = gain_prod + ROUND_BIAS;
  assign y_full  = rounded[GPROD_W-1:ROUND_SHIFT];

  always_comb begin
    priority if (y_full > Y_MAX) begin
      y_sat  = OUT_MAX;
      y_clip = 1'b1;
    end else if (y_full < Y_MIN) begin
      y_sat  = OUT_MIN;
      y_clip = 1'b1;
    end else begin
      y_sat  = y_full[SAMPLE_W-1:0];
      y_clip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      sample_out <= y_sat;
      saturated  <= y_clip;
    end
  end

  assign status.clear_last = (clr_addr == LAST_ADDR);
  assign status.mod_done   = mod_done;
  assign status.mac_last   = (tap_cnt == '0);
  assign status.sum_ready  = sum_ready;
  assign status.out_busy   = result_valid && result_stall;

endmodule

@@ hdl/firsa_checker.sv @@
`include "fir_filter_scatter_accumulate_macros.svh"

module firsa_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   item_valid,
  input logic                                   item_stall,
  input logic                                   opcode,
  input logic                                   result_valid,
  input logic                                   result_stall,
  input logic signed [firsa_pkg::SAMPLE_W-1:0]  sample_out,
  input logic                                   saturated
);
  import firsa_pkg::*;

  logic item_accept;

  assign item_accept = item_valid && !item_stall;

  `FIRSA_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid && $stable(sample_out) && $stable(saturated))
  `FIRSA_ASSERT_SAME(a_clear_after_reset, $past(rst), item_stall)
  `FIRSA_ASSERT_NEXT(a_load_gives_nothing, item_accept && (opcode == OP_LOAD_TAP), !$rose(result_valid))
  `FIRSA_ASSERT_NEXT(a_sample_busy, item_accept && (opcode == OP_SAMPLE), item_stall)
  `FIRSA_ASSERT_SAME(a_clip_at_rail, result_valid && saturated, (sample_out == OUT_MAX) || (sample_out == OUT_MIN))

endmodule

bind fir_filter_scatter_accumulate firsa_checker u_firsa_checker (.*);

@@ tb/tb_fir_filter_scatter_accumulate.sv @@
`timescale 1ns / 100ps

module tb_fir_filter_scatter_accumulate;
  import firsa_pkg::*;

  localparam int MAX_TAPS      = 64;
  localparam int TOTAL_BEATS   = 1350;
  localparam int QUIET_BEATS   = 200;
  localparam int SETTLE_CYCLES = 2 * MAX_TAPS + 16;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int N_DIRECTED    = 29;
  localparam int Q_SHIFT       = 29;
  localparam longint SAMPLE_TOP    = 8388607;
  localparam longint SAMPLE_BOTTOM = -8388608;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       saturated;
  } filt_out_t;

  typedef enum logic [1:0] {ROW_REG, ROW_BEAT, ROW_BEAT_KNOWN} row_kind_t;
  typedef enum int unsigned {VAL_FULL, VAL_SMALL, VAL_EXTREME, VAL_MIXED} value_style_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic [CFG_INDEX_W-1:0]     reg_index;
    logic [CFG_DATA_W-1:0]      reg_data;
    logic                       op;
    logic signed [SAMPLE_W-1:0] x;
    logic [INDEX_W-1:0]         idx;
    logic signed [TAP_W-1:0]    coef;
    logic signed [SAMPLE_W-1:0] want_out;
    logic                       want_sat;
  } stim_row_t;

  logic                       clk          = 1'b0;
  logic                       rst          = 1'b1;
  logic                       item_valid   = 1'b0;
  logic                       opcode       = OP_SAMPLE;
  logic signed [SAMPLE_W-1:0] sample_in    = '0;
  logic [INDEX_W-1:0]         tap_index    = '0;
  logic signed [TAP_W-1:0]    tap_value    = '0;
  logic                       result_stall = 1'b0;
  logic                       cfg_write    = 1'b0;
  logic [CFG_INDEX_W-1:0]     cfg_index    = REG_TAP_COUNT;
  logic [CFG_DATA_W-1:0]      cfg_data     = '0;
  logic                       item_stall;
  logic                       result_valid;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       saturated;

  fir_filter_scatter_accumulate #(.MAX_TAPS(MAX_TAPS)) dut (.*);

  logic signed [TAP_W-1:0]  coef_mem     [MAX_TAPS];
  logic signed [ACC_W-1:0]  partial_sums [MAX_TAPS];
  int unsigned              ring_pos;
  logic [COUNT_W-1:0]       taps_reg;
  logic signed [GAIN_W-1:0] gain_reg;

  filt_out_t pending_outputs [$];
  filt_out_t arrived;
  int        error_count = 0;
  int        cycle_count = 0;
  int        beats_sent  = 0;
  int        gap_pct     = 0;
  int        stall_pct   = 0;
  int        stall_left  = 0;

  stim_row_t directed [N_DIRECTED] = '{
    '{ROW_BEAT_KNOWN, REG_TAP_COUNT,   0,      OP_SAMPLE,   8388607,  0,  0,       0,        0},
    '{ROW_BEAT_KNOWN, REG_TAP_COUNT,   0,      OP_SAMPLE,   -8388608, 0,  0,       0,        0},
    '{ROW_REG,        REG_TAP_COUNT,   1,      OP_SAMPLE,   0,        0,  0,       0,        0},
    '{ROW_REG,        REG_OUTPUT_GAIN, 32767,  OP_SAMPLE,   0,        0,  0,       0,        0},
    '{ROW_BEAT,       REG_TAP_COUNT,   0,      OP_LOAD_TAP, 0,        0,  -131072, 0,        0},
    '{ROW_BEAT_KNOWN, REG_TAP_COUNT,   0,      OP_SAMPLE,   -8388608, 0,  0,       8388607,  1},
    '{ROW_BEAT_KNOWN, REG_TAP_COUNT,   0,      OP_SAMPLE,   8388607,  0,  0,       -8388608, 1},
    '{ROW_BEAT_KNOWN, REG_TAP_COUNT,   0,      OP_SAMPLE,   0,        0,  0,       0,        0},
    '{ROW_REG,        REG_OUTPUT_GAIN, -32768, OP_SAMPLE,   0,        0,  0,       0,        0},
    '{ROW_BEAT_KNOWN, REG_TAP_COUNT,   0,      OP_SAMPLE,   8388607,  0,  0,       8388607,  1},
    '{ROW_REG,        REG_OUTPUT_GAIN, 0,      OP_SAMPLE,   0,        0,  0,       0,        0},
    '{ROW_BEAT_KNOWN, REG_TAP_COUNT,   0,      OP_SAMPLE,   -8388608, 0,  0,       0,        0},
    '{ROW_REG,        REG_OUTPUT_GAIN, 4096,   OP_SAMPLE,   0,        0,  0,       0,        0},
    '{ROW_REG,        REG_TAP_COUNT,   0,      OP_SAMPLE,   0,        0,  0,       0,        0},
    '{ROW_BEAT,       REG_TAP_COUNT,   0,      OP_LOAD_TAP, 0,        0,  131071,  0,        0},
    '{ROW_BEAT,       REG_TAP_COUNT,   0,      OP_SAMPLE,   1234567,  0,  0,       0,        0},
    '{ROW_REG,        REG_TAP_COUNT,   127,    OP_SAMPLE,   0,        0,  0,       0,        0},
    '{ROW_BEAT,       REG_TAP_COUNT,   0,      OP_LOAD_TAP, 0,        63, 65536,   0,        0},
    '{ROW_BEAT,       REG_TAP_COUNT,   0,      OP_LOAD_TAP, 0,        1,  -100000, 0,        0},
    '{ROW_BEAT,       REG_TAP_COUNT,   0,      OP_SAMPLE,   -8388608, 0,  0,       0,        0},
    '{ROW_BEAT,       REG_TAP_COUNT,   0,      OP_SAMPLE,   8388607,  0,  0,       0,        0},
    '{ROW_BEAT,       REG_TAP_COUNT,   0,      OP_SAMPLE,   4000000,  0,  0,       0,        0},
    '{ROW_REG,        REG_TAP_COUNT,   5,      OP_SAMPLE,   0,        0,  0,       0,        0},
    '{ROW_BEAT,       REG_TAP_COUNT,   0,      OP_LOAD_TAP, 0,        50, 77777,   0,        0},
    '{ROW_BEAT,       REG_TAP_COUNT,   0,      OP_SAMPLE,   777,      0,  0,       0,        0},
    '{ROW_BEAT,       REG_TAP_COUNT,   0,      OP_SAMPLE,   -555,     0,  0,       0,        0},
    '{ROW_BEAT,       REG_TAP_COUNT,   0,      OP_SAMPLE,   3,        0,  0,       0,        0},
    '{ROW_REG,        REG_TAP_COUNT,   64,     OP_SAMPLE,   0,        0,  0,       0,        0},
    '{ROW_BEAT,       REG_TAP_COUNT,   0,      OP_SAMPLE,   -1,       0,  0,       0,        0}
  };

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    error_count++;
    $display("[cycle %0d] mismatch: %s", cycle_count, msg);
  endtask

  function automatic int unsigned taps_in_use();
    if (taps_reg == '0) return 1;
    if (taps_reg > MAX_TAPS) return MAX_TAPS;
    return 32'(taps_reg);
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  function automatic longint pick_value(input value_style_t style, input int unsigned bits);
    longint       top;
    value_style_t s;
    top = (longint'(1) <<< (bits - 1)) - 1;
    s = (style == VAL_MIXED) ? value_style_t'($urandom_range(0, 2)) : style;
    case (s)
      VAL_FULL: return longint'($urandom_range(0, 32'(2 * top + 1))) - top - 1;
      VAL_SMALL: return longint'($urandom_range(0, 2047)) - 1024;
      default: return $urandom_range(0, 1) ? top : -top - 1;
    endcase
  endfunction

  // Loads a tap, or scatters a sample into the partial-sum ring and outputs the due slot.
  function automatic bit filter_step(input logic op, input logic signed [SAMPLE_W-1:0] x,
                                     input logic [INDEX_W-1:0] idx,
                                     input logic signed [TAP_W-1:0] coef,
                                     output filt_out_t y);
    int unsigned n, p, slot, j;
    longint      sum, scaled;
    y = '0;
    if (op == OP_LOAD_TAP) begin
      coef_mem[idx] = coef;
      return 1'b0;
    end
    n = taps_in_use();
    p = ring_pos % n;
    for (j = 0; j < n; j++) begin
      slot = (p + j) % n;
      sum = longint'(partial_sums[slot]) + longint'(x) * longint'(coef_mem[n - 1 - j]);
      partial_sums[slot] = sum[ACC_W-1:0];
    end
    slot = (p + n - 1) % n;
    scaled = (longint'(partial_sums[slot]) * longint'(gain_reg)
              + (longint'(1) <<< (Q_SHIFT - 1))) >>> Q_SHIFT;
    partial_sums[slot] = '0;
    ring_pos = slot;
    if (scaled > SAMPLE_TOP) begin
      y.sample_out = SAMPLE_TOP[SAMPLE_W-1:0];
      y.saturated  = 1'b1;
    end else if (scaled < SAMPLE_BOTTOM) begin
      y.sample_out = SAMPLE_BOTTOM[SAMPLE_W-1:0];
      y.saturated  = 1'b1;
    end else begin
      y.sample_out = scaled[SAMPLE_W-1:0];
    end
    return 1'b1;
  endfunction

  task automatic rest(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      item_valid <= 1'b0;
    end
  endtask

  task automatic settle();
    rest(1);
    while (pending_outputs.size() != 0) @(posedge clk);
    rest(SETTLE_CYCLES);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] which,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= which;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (which == REG_TAP_COUNT) taps_reg = data[COUNT_W-1:0];
    else gain_reg = data[GAIN_W-1:0];
  endtask

  task automatic send_beat(input logic op, input logic signed [SAMPLE_W-1:0] x,
                           input logic [INDEX_W-1:0] idx, input logic signed [TAP_W-1:0] coef,
                           input bit known, input filt_out_t known_out);
    filt_out_t predicted;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) rest($urandom_range(1, 16));
    @(negedge clk);
    item_valid <= 1'b1;
    opcode     <= op;
    sample_in  <= x;
    tap_index  <= idx;
    tap_value  <= coef;
    do @(posedge clk); while (item_stall);
    if (filter_step(op, x, idx, coef, predicted))
      pending_outputs.push_back(known ? known_out : predicted);
    beats_sent++;
  endtask

  always @(negedge clk) begin
    if (stall_left != 0) begin
      result_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      result_stall <= 1'b1;
      stall_left = $urandom_range(0, 15);
    end else begin
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_outputs.size() == 0) begin
        flag_error($sformatf("output beat %0d with nothing outstanding", sample_out));
      end else begin
        arrived = pending_outputs.pop_front();
        if (sample_out !== arrived.sample_out)
          flag_error($sformatf("sample_out %0d, predicted %0d", sample_out, arrived.sample_out));
        if (saturated !== arrived.saturated)
          flag_error($sformatf("saturated %0b, predicted %0b", saturated, arrived.saturated));
      end
    end
  end

  initial begin
    int unsigned            k, n_use, burst;
    bit                     quiet;
    value_style_t           coef_style, x_style;
    logic [CFG_DATA_W-1:0]  word;
    stim_row_t              row;

    for (k = 0; k < MAX_TAPS; k++) begin
      coef_mem[k]     = '0;
      partial_sums[k] = '0;
    end
    ring_pos = 0;
    taps_reg = TAP_COUNT_RESET;
    gain_reg = OUTPUT_GAIN_RESET;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    gap_pct   = 25;
    stall_pct = 25;
    for (k = 0; k < N_DIRECTED; k++) begin
      row = directed[k];
      case (row.kind)
        ROW_REG: begin
          settle();
          write_reg(row.reg_index, row.reg_data);
        end
        ROW_BEAT: send_beat(row.op, row.x, row.idx, row.coef, 1'b0, '0);
        default: send_beat(row.op, row.x, row.idx, row.coef, 1'b1,
                           '{row.want_out, row.want_sat});
      endcase
    end

    // Each phase waits for the block to drain, reconfigures it, in most phases reloads
    // the taps in use, and then streams samples with the odd stray tap load mixed in.
    while (beats_sent < TOTAL_BEATS) begin
      quiet = beats_sent > TOTAL_BEATS - QUIET_BEATS;
      settle();
      case ($urandom_range(0, 6))
        0: word = 1;
        1: word = 64;
        2: word = 0;
        3: word = 127;
        4, 5: word = CFG_DATA_W'($urandom_range(2, 8));
        default: word = CFG_DATA_W'($urandom_range(0, 127));
      endcase
      write_reg(REG_TAP_COUNT, word);
      case ($urandom_range(0, 5))
        0: word = 16'h8000;
        1: word = 16'h7fff;
        2: word = 4096;
        3: word = 0;
        4: word = CFG_DATA_W'($urandom_range(0, 255) - 128);
        default: word = CFG_DATA_W'($urandom);
      endcase
      write_reg(REG_OUTPUT_GAIN, word);
      gap_pct    = quiet ? 0 : pick_pct();
      stall_pct  = quiet ? 0 : pick_pct();
      coef_style = value_style_t'($urandom_range(0, 3));
      x_style    = value_style_t'($urandom_range(0, 3));
      n_use      = taps_in_use();
      if ($urandom_range(0, 3) != 0) begin
        for (k = 0; k < n_use; k++)
          send_beat(OP_LOAD_TAP, SAMPLE_W'($urandom), INDEX_W'(k),
                    TAP_W'(pick_value(coef_style, TAP_W)), 1'b0, '0);
      end
      burst = $urandom_range(15, 50);
      for (k = 0; k < burst; k++) begin
        if ($urandom_range(0, 19) == 0)
          send_beat(OP_LOAD_TAP, SAMPLE_W'($urandom),
                    INDEX_W'($urandom_range(0, MAX_TAPS - 1)),
                    TAP_W'(pick_value(coef_style, TAP_W)), 1'b0, '0);
        else
          send_beat(OP_SAMPLE, SAMPLE_W'(pick_value(x_style, SAMPLE_W)),
                    INDEX_W'($urandom), TAP_W'($urandom), 1'b0, '0);
      end
    end

    rest(1);
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
